/* rtl/lru_key_value_cache_defines.svh */
// Assertion macros used by the cache top level.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUKV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRUKV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lrukv_pkg.sv */
// Package with the types and constants of the LRU key-value cache.
package lrukv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BITS        = 16;
  localparam int VALUE_BITS      = 32;
  localparam int CAP_BITS        = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } rsp_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic lookup;     // capture the match-at-or-below flag
    logic shift_sel;  // shift cells up to and including the hit position
    logic shift_all;  // shift the whole row to make room at the front
    logic evict;      // the entry at the current count position is dropped
  } ctl_t;

endpackage

/* rtl/lrukv_cell.sv */
// One cell of the recency-ordered row: holds one entry and its place in the order.
module lrukv_cell #(
  parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF,
  parameter int INDEX       = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lrukv_pkg::ctl_t                      ctl,
  input  logic [lrukv_pkg::KEY_BITS-1:0]       req_key,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]     count,
  input  logic [lrukv_pkg::KEY_BITS-1:0]       left_key,
  input  logic [lrukv_pkg::VALUE_BITS-1:0]     left_value,
  input  logic                                 left_valid,
  input  logic                                 right_valid,
  input  logic                                 sel_in,
  input  logic [lrukv_pkg::VALUE_BITS-1:0]     val_in,
  input  logic [lrukv_pkg::KEY_BITS-1:0]       evk_in,
  output logic                                 sel_out,
  output logic [lrukv_pkg::VALUE_BITS-1:0]     val_out,
  output logic [lrukv_pkg::KEY_BITS-1:0]       evk_out,
  output logic [lrukv_pkg::KEY_BITS-1:0]       entry_key,
  output logic [lrukv_pkg::VALUE_BITS-1:0]     entry_value,
  output logic                                 entry_valid
);
  import lrukv_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);

  logic match;
  logic sel;
  logic load;

  assign match   = entry_valid && (entry_key == req_key);
  assign sel_out = match | sel_in;
  assign val_out = match ? entry_value : val_in;
  // The least recent entry is the last valid one in the row.
  assign evk_out = (entry_valid && !right_valid) ? entry_key : evk_in;
  assign load    = ctl.shift_all || (ctl.shift_sel && sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      sel         <= 1'b0;
    end else begin
      if (ctl.lookup) begin
        sel <= sel_out;
      end
      if (load) begin
        entry_valid <= left_valid && !(ctl.evict && (POS == count));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry_key   <= left_key;
      entry_value <= left_value;
    end
  end

endmodule

/* rtl/lru_key_value_cache.sv */
// Top level of the fully associative key-value cache with LRU replacement.
//
//  channel   direction  handshake             payload
//  request   in         start, busy           req   (cmd, key, value)
//  result    out        done (strobe)         rsp   (hit, read_value, evicted, evicted_key)
//  config    in         cfg_we                cfg_wdata (capacity)
//
// A transaction is accepted at a rising edge where start is high and busy is low.
// Each transaction runs through a lookup cycle, in which every cell compares its
// key and the match, hit value and least recent key ripple down the cell row, and an
// update cycle, in which the row shifts and the result is shown with done high.
// A new transaction may be accepted at the end of the update cycle, so a new request
// waits until the row's compare-then-shift sequence for the last one is through.
// Reset is synchronous and empties the store; capacity returns to sixteen entries.
// The result is presented for exactly one cycle; the receiver cannot stall it.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  lrukv_pkg::req_t                   req,
  input  logic                              cfg_we,
  input  logic [lrukv_pkg::CAP_BITS-1:0]    cfg_wdata,
  output logic                              done,
  output lrukv_pkg::rsp_t                   rsp
);
  import lrukv_pkg::*;
  `include "lru_key_value_cache_defines.svh"

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);
  localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1);

  state_t state, state_next;
  ctl_t   ctl;
  logic   accept;

  // Request held for the whole transaction.
  req_t                  req_q;
  logic [CAP_BITS-1:0]   capacity;
  logic [CNT_W-1:0]      count;

  // Results of the lookup cycle.
  logic                  hit_q;
  logic [VALUE_BITS-1:0] hit_val_q;
  logic [KEY_BITS-1:0]   evk_q;
  logic                  evict_q;

  // Chains through the cell row; index MAX_ENTRIES is the far end of the row.
  logic                  sel_c [MAX_ENTRIES+1];
  logic [VALUE_BITS-1:0] val_c [MAX_ENTRIES+1];
  logic [KEY_BITS-1:0]   evk_c [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:0]  valid_vec;
  logic [KEY_BITS-1:0]   key_a [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] value_a [MAX_ENTRIES];

  logic [KEY_BITS-1:0]   front_key;
  logic [VALUE_BITS-1:0] front_value;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic                  is_put;
  logic                  evict_now;

  assign accept = start && !busy;
  assign is_put = (req_q.cmd == CMD_PUT);

  // A capacity of zero behaves as one; anything above the row length saturates.
  assign cap_ext = CMP_W'(capacity);
  always_comb begin
    priority if (cap_ext == '0) begin
      cap_eff = ONE_CMP;
    end else if (cap_ext > MAX_CMP) begin
      cap_eff = MAX_CMP;
    end else begin
      cap_eff = cap_ext;
    end
  end

  // A put that misses evicts the last valid entry when the store is at capacity.
  assign evict_now = is_put && !sel_c[0] && (CMP_W'(count) >= cap_eff);

  assign sel_c[MAX_ENTRIES] = 1'b0;
  assign val_c[MAX_ENTRIES] = '0;
  assign evk_c[MAX_ENTRIES] = '0;
  assign valid_vec[MAX_ENTRIES] = 1'b0;

  // The front of the row receives the request key, with either the new value or the
  // value that the hit found.
  assign front_key   = req_q.key;
  assign front_value = is_put ? req_q.value : hit_val_q;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0]   left_key;
    logic [VALUE_BITS-1:0] left_value;
    logic                  left_valid;

    if (i == 0) begin : g_front
      assign left_key   = front_key;
      assign left_value = front_value;
      assign left_valid = 1'b1;
    end else begin : g_inner
      assign left_key   = key_a[i-1];
      assign left_value = value_a[i-1];
      assign left_valid = valid_vec[i-1];
    end

    lrukv_cell #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .req_key    (req_q.key),
      .count      (count),
      .left_key   (left_key),
      .left_value (left_value),
      .left_valid (left_valid),
      .right_valid(valid_vec[i+1]),
      .sel_in     (sel_c[i+1]),
      .val_in     (val_c[i+1]),
      .evk_in     (evk_c[i+1]),
      .sel_out    (sel_c[i]),
      .val_out    (val_c[i]),
      .evk_out    (evk_c[i]),
      .entry_key  (key_a[i]),
      .entry_value(value_a[i]),
      .entry_valid(valid_vec[i])
    );
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl           = '0;
    busy          = 1'b0;
    done          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        busy       = 1'b1;
        ctl.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        done          = 1'b1;
        ctl.shift_sel = hit_q;
        ctl.shift_all = is_put && !hit_q;
        ctl.evict     = evict_q;
        state_next    = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (ctl.shift_all && !evict_q) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Request capture and lookup results; these are payload and need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (ctl.lookup) begin
      hit_q     <= sel_c[0];
      hit_val_q <= val_c[0];
      evk_q     <= evk_c[0];
      evict_q   <= evict_now;
    end
  end

  always_comb begin
    rsp             = '0;
    rsp.hit         = hit_q;
    rsp.read_value  = (!is_put && hit_q) ? hit_val_q : '0;
    rsp.evicted     = evict_q;
    rsp.evicted_key = evict_q ? evk_q : '0;
  end

  // The number of valid cells always equals the entry count.
  `LRUKV_ASSERT_SAME(a_count_matches_valid, clk, rst, 1'b1, $countones(valid_vec) == int'(count), "entry count disagrees with valid cells")
  // Every lookup cycle is followed by the result strobe.
  `LRUKV_ASSERT_NEXT(a_lookup_then_result, clk, rst, state == ST_LOOKUP, done, "result did not follow lookup")
  // Only a put that misses may evict.
  `LRUKV_ASSERT_SAME(a_evict_on_put_miss, clk, rst, done && rsp.evicted, is_put && !rsp.hit, "eviction outside a put miss")
  // A full row always evicts on a put miss, so the count never passes the row length.
  `LRUKV_ASSERT_SAME(a_count_bounded, clk, rst, 1'b1, CMP_W'(count) <= MAX_CMP, "entry count beyond row length")

endmodule
